/* src/tksd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Terminal key sequence decoder package
// Event codes, virtual key codes and the command word passed from the
// classifier to the event sequencer.
// ---------------------------------------------------------------------------
package tksd_pkg;

    localparam logic [2:0] EV_CHAR    = 3'd0;
    localparam logic [2:0] EV_DOWN    = 3'd1;
    localparam logic [2:0] EV_UP      = 3'd2;
    localparam logic [2:0] EV_RELOAD  = 3'd3;
    localparam logic [2:0] EV_FORWARD = 3'd4;
    localparam logic [2:0] EV_BACK    = 3'd5;
    localparam logic [2:0] EV_QUIT    = 3'd6;

    localparam logic [6:0] K_BACK   = 7'h08;
    localparam logic [6:0] K_TAB    = 7'h09;
    localparam logic [6:0] K_RETURN = 7'h0D;
    localparam logic [6:0] K_PGUP   = 7'h21;
    localparam logic [6:0] K_PGDN   = 7'h22;
    localparam logic [6:0] K_END    = 7'h23;
    localparam logic [6:0] K_HOME   = 7'h24;
    localparam logic [6:0] K_LEFT   = 7'h25;
    localparam logic [6:0] K_UP     = 7'h26;
    localparam logic [6:0] K_RIGHT  = 7'h27;
    localparam logic [6:0] K_DOWN   = 7'h28;
    localparam logic [6:0] K_DELETE = 7'h2E;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // pair = 1: down, up and, if ch is non-zero, char; else a single event
    typedef struct packed {
        logic       pair;
        logic [2:0] kind;
        logic [6:0] key;
        logic [6:0] ch;
    } tksd_cmd_t;

endpackage
`default_nettype wire

/* src/tksd_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Byte classifier
// Tracks escape sequences and the tilde number, and turns each byte into
// at most one command word.
// ---------------------------------------------------------------------------
module tksd_front #(
    parameter int SEQUENCE_LIMIT = 63
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    output logic                    cmd_valid,
    output tksd_pkg::tksd_cmd_t     cmd
);
    import tksd_pkg::*;

    localparam int LEN_W = $clog2(SEQUENCE_LIMIT + 1);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [LEN_W-1:0] seq_reg, seq_next;
    logic             bracket_reg, bracket_next;
    logic [7:0]       p0_reg, p0_next;
    logic [7:0]       p1_reg, p1_next;
    logic [7:0]       p2_reg, p2_next;
    logic [7:0]       num_reg, num_next;
    logic [1:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;

    logic [LEN_W-1:0] len;
    logic             is_digit;
    logic             is_space;
    logic             closer;
    logic [11:0]      prod;
    logic [11:0]      sum;
    logic [7:0]       digit_val;

    assign is_digit  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign is_space  = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
    assign closer    = ((rx_byte >= 8'h41) && (rx_byte <= 8'h5A))
                    || ((rx_byte >= 8'h61) && (rx_byte <= 8'h7A)) || (rx_byte == 8'h7E);
    assign prod      = {4'd0, num_reg} * 12'd10;
    assign sum       = prod + {8'd0, rx_byte[3:0]};
    assign digit_val = (sum > 12'd255) ? 8'hFF : sum[7:0];
    assign len       = seq_reg + LEN_W'(1);

    always_comb
    begin
        seq_next     = seq_reg;
        bracket_next = bracket_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        num_next     = num_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        cmd_valid    = 1'b0;
        cmd          = '0;

        if (rx_byte == 8'h1B)
        begin
            seq_next   = LEN_W'(1);
            num_next   = 8'd0;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
        end
        else if (seq_reg != '0)
        begin
            if (seq_reg == LEN_W'(1))
                bracket_next = (rx_byte == 8'h5B);
            if (seq_reg == LEN_W'(2))
                p0_next = rx_byte;
            if (seq_reg == LEN_W'(3))
                p1_next = rx_byte;
            if (seq_reg == LEN_W'(4))
                p2_next = rx_byte;

            if (seq_reg >= LEN_W'(2))
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (is_space)
                            phase_next = PH_SKIP;
                        else if ((rx_byte == 8'h2B) || (rx_byte == 8'h2D))
                        begin
                            neg_next   = (rx_byte == 8'h2D);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            num_next   = digit_val;
                            phase_next = PH_DIGITS;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            num_next   = digit_val;
                            phase_next = PH_DIGITS;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end

            seq_next = len;
            if ((len >= LEN_W'(3)) && bracket_next && closer)
            begin
                seq_next = '0;
                if ((len == LEN_W'(6)) && (p0_next == 8'h31) && (p1_next == 8'h3B)
                    && (p2_next == 8'h35) && ((rx_byte == 8'h43) || (rx_byte == 8'h44)))
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = (rx_byte == 8'h43) ? EV_FORWARD : EV_BACK;
                end
                else if ((len == LEN_W'(3)) && ((rx_byte == 8'h41) || (rx_byte == 8'h42)
                    || (rx_byte == 8'h43) || (rx_byte == 8'h44) || (rx_byte == 8'h48)
                    || (rx_byte == 8'h46)))
                begin
                    cmd_valid = 1'b1;
                    cmd.pair  = 1'b1;
                    unique case (rx_byte)
                        8'h41:   cmd.key = K_UP;
                        8'h42:   cmd.key = K_DOWN;
                        8'h43:   cmd.key = K_RIGHT;
                        8'h44:   cmd.key = K_LEFT;
                        8'h48:   cmd.key = K_HOME;
                        default: cmd.key = K_END;
                    endcase
                end
                else if ((rx_byte == 8'h7E) && !neg_next)
                begin
                    cmd.pair = 1'b1;
                    unique case (num_next)
                        8'd1:
                        begin
                            cmd_valid = 1'b1;
                            cmd.key   = K_HOME;
                        end
                        8'd3:
                        begin
                            cmd_valid = 1'b1;
                            cmd.key   = K_DELETE;
                        end
                        8'd4:
                        begin
                            cmd_valid = 1'b1;
                            cmd.key   = K_END;
                        end
                        8'd5:
                        begin
                            cmd_valid = 1'b1;
                            cmd.key   = K_PGUP;
                        end
                        8'd6:
                        begin
                            cmd_valid = 1'b1;
                            cmd.key   = K_PGDN;
                        end
                        default: cmd_valid = 1'b0;
                    endcase
                end
            end
            else if (len >= LEN_W'(SEQUENCE_LIMIT))
                seq_next = '0;
        end
        else
        begin
            priority if ((rx_byte == 8'h0D) || (rx_byte == 8'h0A))
            begin
                cmd_valid = 1'b1;
                cmd.pair  = 1'b1;
                cmd.key   = K_RETURN;
                cmd.ch    = 7'h0D;
            end
            else if (rx_byte == 8'h09)
            begin
                cmd_valid = 1'b1;
                cmd.pair  = 1'b1;
                cmd.key   = K_TAB;
                cmd.ch    = 7'h09;
            end
            else if (rx_byte == 8'h7F)
            begin
                cmd_valid = 1'b1;
                cmd.pair  = 1'b1;
                cmd.key   = K_BACK;
                cmd.ch    = 7'h08;
            end
            else if ((rx_byte >= 8'h20) && (rx_byte < 8'h7F))
            begin
                cmd_valid = 1'b1;
                cmd.kind  = EV_CHAR;
                cmd.key   = rx_byte[6:0];
                cmd.ch    = rx_byte[6:0];
            end
            else if (rx_byte == 8'h18)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = EV_QUIT;
            end
            else if (rx_byte == 8'h12)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = EV_RELOAD;
            end
            else if ((rx_byte >= 8'h01) && (rx_byte <= 8'h1A))
            begin
                cmd_valid = 1'b1;
                cmd.pair  = 1'b1;
                cmd.key   = rx_byte[6:0] + 7'd64;
                cmd.ch    = rx_byte[6:0];
            end
            else
                cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '0;
            num_reg   <= 8'd0;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
        end
        else if (accept)
        begin
            seq_reg   <= seq_next;
            num_reg   <= num_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bracket_reg <= bracket_next;
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
        end
    end

endmodule
`default_nettype wire

/* src/tksd_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Command queue
// Short register queue between the classifier and the event sequencer.
// ---------------------------------------------------------------------------
module tksd_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  tksd_pkg::tksd_cmd_t      push_data,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output tksd_pkg::tksd_cmd_t      head
);
    import tksd_pkg::*;

    tksd_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* src/tksd_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Event sequencer
// Expands each command word into one to three output words, one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module tksd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_ready,
    input  tksd_pkg::tksd_cmd_t      head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               event_kind,
    output logic [6:0]               vkey,
    output logic [6:0]               character,
    output logic                     last_of_run
);
    import tksd_pkg::*;

    logic       load;
    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [2:0] kind_reg, kind_next;
    logic [6:0] key_reg, key_next;
    logic [6:0] ch_reg, ch_next;
    logic       last_reg, last_next;

    assign load = cmd_ready && (!valid_reg || out_ready);
    assign pop  = load && last_next;

    always_comb
    begin
        kind_next = head.kind;
        key_next  = head.key;
        ch_next   = head.ch;
        last_next = 1'b1;
        if (head.pair)
        begin
            unique case (step_reg)
                2'd0:
                begin
                    kind_next = EV_DOWN;
                    ch_next   = 7'd0;
                    last_next = 1'b0;
                end
                2'd1:
                begin
                    kind_next = EV_UP;
                    ch_next   = 7'd0;
                    last_next = (head.ch == 7'd0);
                end
                default:
                    kind_next = EV_CHAR;
            endcase
        end

        valid_next = valid_reg && !out_ready;
        step_next  = step_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = last_next ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            key_reg  <= key_next;
            ch_reg   <= ch_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign vkey        = key_reg;
    assign character   = ch_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

/* src/terminal_key_sequence_decoder_core.sv */
// Path: a command word passes through the command queue and then the event sequencer's output register.
// Throughput: one byte per cycle while the two-entry command queue has room;
// results leave one word per cycle while m_tready is high, so a byte yields 0 to 3 output words.
// The output register and the event sequencer set the sustained rate.
// Reset: clears sequence tracking, the tilde number, the queue and m_tvalid.
`default_nettype none
// ---------------------------------------------------------------------------
// Terminal key sequence decoder
// Decodes terminal bytes and escape sequences into key and action events.
// ---------------------------------------------------------------------------
module terminal_key_sequence_decoder_core #(
    parameter int SEQUENCE_LIMIT = 63
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] event_kind, [9:3] vkey, [16:10] character
    output logic             m_tlast    // last_of_run
);
    import tksd_pkg::*;

    logic      accept;
    logic      cmd_valid;
    tksd_cmd_t cmd;
    logic      q_full;
    logic      q_not_empty;
    tksd_cmd_t q_head;
    logic      q_pop;
    logic      push;
    logic [2:0] event_kind;
    logic [6:0] vkey;
    logic [6:0] character;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && cmd_valid;

    tksd_front #(
        .SEQUENCE_LIMIT (SEQUENCE_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    tksd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tksd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ready   (q_not_empty),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .event_kind  (event_kind),
        .vkey        (vkey),
        .character   (character),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {7'd0, character, vkey, event_kind};

    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_full))
        else $error("command pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("event run broken off before its last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == EV_DOWN)) |-> !m_tlast)
        else $error("key down marked as last word");

endmodule
`default_nettype wire
